/* src/assert_macros.svh */
// Assertion macros shared by the RTL files of the lexer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define CHK_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

// When the trigger holds, the condition must hold in the following cycle.
`define CHK_NEXT(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error(msg);

`endif

/* src/cltl_pkg.sv */
// Types, constants and character classes of the command line token lexer.
package cltl_pkg;

  localparam int MaxTokenLen = 255;
  localparam int TokLenW     = $clog2(MaxTokenLen + 1);
  localparam int OutLenMax   = 255;

  typedef enum logic [3:0] {
    K_END    = 4'd0,
    K_DDASH  = 4'd1,
    K_SDASH  = 4'd2,
    K_HEX    = 4'd3,
    K_INT    = 4'd4,
    K_FLOAT  = 4'd5,
    K_BOOL   = 4'd6,
    K_WORD   = 4'd7,
    K_COLON  = 4'd8,
    K_EQUALS = 4'd9,
    K_COMMA  = 4'd10,
    K_ERROR  = 4'd11
  } kind_t;

  typedef enum logic [10:0] {
    S_START = 11'b000_0000_0001,
    S_DASH  = 11'b000_0000_0010,
    S_ZERO  = 11'b000_0000_0100,
    S_INT   = 11'b000_0000_1000,
    S_HEX   = 11'b000_0001_0000,
    S_FRAC  = 11'b000_0010_0000,
    S_EXP0  = 11'b000_0100_0000,
    S_EXPS  = 11'b000_1000_0000,
    S_EXPD  = 11'b001_0000_0000,
    S_BAD   = 11'b010_0000_0000,
    S_WORD  = 11'b100_0000_0000
  } state_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] len;
  } res_t;

  typedef struct packed {
    logic two;
    res_t r0;
    res_t r1;
  } pair_t;

  // Keywords: true, false, on, off.
  localparam logic [7:0] KwText [4][5] = '{
    '{"t", "r", "u", "e", 8'h00},
    '{"f", "a", "l", "s", "e"},
    '{"o", "n", 8'h00, 8'h00, 8'h00},
    '{"o", "f", "f", 8'h00, 8'h00}
  };
  localparam int KwLen [4] = '{4, 5, 2, 3};

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_xdigit(input logic [7:0] c);
    return is_digit(c) || ((c >= "a") && (c <= "f")) || ((c >= "A") && (c <= "F"));
  endfunction

  function automatic logic is_delim(input logic [7:0] c);
    return (c == 8'h00) || (c == "-") || (c == ":") || (c == "=") || (c == ",");
  endfunction

  function automatic logic is_exp(input logic [7:0] c);
    return (c == "e") || (c == "E");
  endfunction

  // Length as reported on the output, held at 255.
  function automatic logic [7:0] out_len(input logic [TokLenW-1:0] len);
    logic [31:0] wide;
    wide = 32'(len);
    return (wide > 32'(OutLenMax)) ? 8'hFF : wide[7:0];
  endfunction

endpackage

/* src/command_line_token_lexer.sv */
// Command line token lexer: one character per word in, token kinds and lengths out.
//
//  channel | direction | tdata                  | tuser / tlast
//  --------+-----------+------------------------+-----------------------------
//  in_     | slave     | [7:0] ch               | tuser: cmd (1 = end of input)
//  out_    | master    | [3:0] kind, [11:4] len | tlast: last result of a word
//
// Every input word is lexed in the cycle it is accepted; its results (zero, one or
// two) go to a two-entry queue of result pairs, so an input word is taken every cycle
// while entry B is free. The output drains one result per cycle while out_tready is high,
// so words that cause two results can fill the queue and hold back the input.
// Reset (rst_n low, synchronous) returns the lexer to its idle state and empties the queue.
// in_tready falls only while the second queue entry is occupied by a stalled result pair.
`include "assert_macros.svh"

module command_line_token_lexer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] ch
  input  logic        in_tuser,   // [0] cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [3:0] kind, [11:4] length, [15:12] zero
  output logic        out_tlast
);

  localparam int LW = cltl_pkg::TokLenW;

  // Lexer state.
  cltl_pkg::state_t st_r, st_nxt;
  logic [LW-1:0]    len_r, len_nxt;
  logic [3:0]       wm_r, wm_nxt;

  // Result queue: entry A is on the output, entry B waits behind it.
  logic             a_valid_r, a_valid_nxt;
  cltl_pkg::pair_t  a_pair_r, a_pair_nxt;
  logic             a_idx_r, a_idx_nxt;
  logic             b_valid_r, b_valid_nxt;
  cltl_pkg::pair_t  b_pair_r, b_pair_nxt;

  logic             in_fire;
  logic [7:0]       c;
  logic [1:0]       n_res;
  cltl_pkg::pair_t  new_pair;

  // Combinational helpers.
  cltl_pkg::kind_t  close_k;
  logic             start_emit;
  cltl_pkg::kind_t  start_k;
  cltl_pkg::state_t start_st;
  logic [LW-1:0]    start_len;
  logic [3:0]       start_wm;
  logic [LW-1:0]    grown;
  logic             do_close;
  cltl_pkg::res_t   cur;
  logic             a_done;
  logic             a_free;

  // Clears keywords that no longer match once c lands at position pos.
  function automatic logic [3:0] match_next(input logic [3:0] wm, input logic [LW-1:0] pos,
                                            input logic [7:0] ch);
    logic [3:0]  m;
    logic [31:0] p;
    m = wm;
    p = 32'(pos);
    for (int i = 0; i < 4; i++) begin
      if (p >= 32'(cltl_pkg::KwLen[i])) begin
        m[i] = 1'b0;
      end else if (cltl_pkg::KwText[i][p[2:0]] != ch) begin
        m[i] = 1'b0;
      end
    end
    return m;
  endfunction

  assign in_fire = in_tvalid && in_tready;
  assign c       = in_tdata;
  assign grown   = (len_r < LW'(cltl_pkg::MaxTokenLen)) ? len_r + LW'(1) : len_r;

  // Kind of the open token when something closes it.
  always_comb begin
    close_k = cltl_pkg::K_ERROR;
    case (st_r)
      cltl_pkg::S_DASH: close_k = cltl_pkg::K_SDASH;
      cltl_pkg::S_ZERO,
      cltl_pkg::S_INT:  close_k = cltl_pkg::K_INT;
      cltl_pkg::S_HEX:  close_k = cltl_pkg::K_HEX;
      cltl_pkg::S_FRAC,
      cltl_pkg::S_EXPD: close_k = cltl_pkg::K_FLOAT;
      cltl_pkg::S_WORD: begin
        close_k = cltl_pkg::K_WORD;
        for (int i = 0; i < 4; i++) begin
          if (wm_r[i] && (32'(len_r) == 32'(cltl_pkg::KwLen[i]))) begin
            close_k = cltl_pkg::K_BOOL;
          end
        end
      end
      default: close_k = cltl_pkg::K_ERROR;
    endcase
  end

  // What the character does when it begins a new token.
  always_comb begin
    start_emit = (c == ":") || (c == "=") || (c == ",");
    start_k    = cltl_pkg::K_COMMA;
    if (c == ":") begin
      start_k = cltl_pkg::K_COLON;
    end else if (c == "=") begin
      start_k = cltl_pkg::K_EQUALS;
    end
    start_wm = 4'd0;
    if ((c == 8'h00) || start_emit) begin
      start_st = cltl_pkg::S_START;
    end else if (c == "-") begin
      start_st = cltl_pkg::S_DASH;
    end else if (c == "0") begin
      start_st = cltl_pkg::S_ZERO;
    end else if (cltl_pkg::is_digit(c)) begin
      start_st = cltl_pkg::S_INT;
    end else begin
      start_st = cltl_pkg::S_WORD;
      start_wm = match_next(4'hF, LW'(0), c);
    end
    start_len = (start_st == cltl_pkg::S_START) ? LW'(0) : LW'(1);
  end

  // One step of the lexer.
  always_comb begin
    st_nxt   = st_r;
    len_nxt  = len_r;
    wm_nxt   = wm_r;
    do_close = 1'b0;
    n_res    = 2'd0;
    new_pair = '{two: 1'b0,
                 r0: '{kind: close_k, len: cltl_pkg::out_len(len_r)},
                 r1: '{kind: start_k, len: 8'd1}};

    if (in_tuser) begin
      // End of input closes any open token, then reports the end.
      if (st_r != cltl_pkg::S_START) begin
        new_pair.r1 = '{kind: cltl_pkg::K_END, len: 8'd0};
        new_pair.two = 1'b1;
        n_res = 2'd2;
      end else begin
        new_pair.r0 = '{kind: cltl_pkg::K_END, len: 8'd0};
        n_res = 2'd1;
      end
      st_nxt  = cltl_pkg::S_START;
      len_nxt = LW'(0);
      wm_nxt  = 4'd0;
    end else begin
      case (st_r)
        cltl_pkg::S_START: begin
          st_nxt  = start_st;
          len_nxt = start_len;
          wm_nxt  = start_wm;
          if (start_emit) begin
            new_pair.r0 = '{kind: start_k, len: 8'd1};
            n_res = 2'd1;
          end
        end
        cltl_pkg::S_DASH: begin
          if (c == "-") begin
            new_pair.r0 = '{kind: cltl_pkg::K_DDASH, len: cltl_pkg::out_len(grown)};
            n_res   = 2'd1;
            st_nxt  = cltl_pkg::S_START;
            len_nxt = LW'(0);
          end else begin
            do_close = 1'b1;
          end
        end
        cltl_pkg::S_ZERO,
        cltl_pkg::S_INT,
        cltl_pkg::S_FRAC: begin
          if (cltl_pkg::is_delim(c)) begin
            do_close = 1'b1;
          end else begin
            len_nxt = grown;
            if (cltl_pkg::is_digit(c) && (st_r != cltl_pkg::S_ZERO)) begin
              st_nxt = st_r;
            end else if (cltl_pkg::is_exp(c)) begin
              st_nxt = cltl_pkg::S_EXP0;
            end else if ((c == ".") && (st_r != cltl_pkg::S_FRAC)) begin
              st_nxt = cltl_pkg::S_FRAC;
            end else if (((c == "x") || (c == "X")) && (st_r == cltl_pkg::S_ZERO)) begin
              st_nxt = cltl_pkg::S_HEX;
            end else begin
              st_nxt = cltl_pkg::S_BAD;
            end
          end
        end
        cltl_pkg::S_HEX: begin
          if (cltl_pkg::is_delim(c)) begin
            do_close = 1'b1;
          end else begin
            len_nxt = grown;
            if (!cltl_pkg::is_xdigit(c)) begin
              st_nxt = cltl_pkg::S_BAD;
            end
          end
        end
        cltl_pkg::S_EXP0,
        cltl_pkg::S_EXPS: begin
          if (cltl_pkg::is_digit(c)) begin
            len_nxt = grown;
            st_nxt  = cltl_pkg::S_EXPD;
          end else if ((c == "-") && (st_r == cltl_pkg::S_EXP0)) begin
            len_nxt = grown;
            st_nxt  = cltl_pkg::S_EXPS;
          end else begin
            do_close = 1'b1;
          end
        end
        cltl_pkg::S_EXPD: begin
          if (cltl_pkg::is_delim(c)) begin
            do_close = 1'b1;
          end else begin
            len_nxt = grown;
            if (!cltl_pkg::is_digit(c)) begin
              st_nxt = cltl_pkg::S_BAD;
            end
          end
        end
        cltl_pkg::S_BAD: begin
          if (cltl_pkg::is_delim(c)) begin
            do_close = 1'b1;
          end else begin
            len_nxt = grown;
          end
        end
        cltl_pkg::S_WORD: begin
          if ((c >= 8'h20) && (c <= 8'h7E) && !cltl_pkg::is_delim(c)) begin
            wm_nxt  = match_next(wm_r, len_r, c);
            len_nxt = grown;
          end else begin
            do_close = 1'b1;
          end
        end
        default: begin
          st_nxt  = cltl_pkg::S_START;
          len_nxt = LW'(0);
          wm_nxt  = 4'd0;
        end
      endcase

      // The open token is reported and the character begins the next one.
      if (do_close) begin
        st_nxt       = start_st;
        len_nxt      = start_len;
        wm_nxt       = start_wm;
        new_pair.two = start_emit;
        n_res        = start_emit ? 2'd2 : 2'd1;
      end
    end
  end

  // Output side of the queue.
  assign cur        = a_idx_r ? a_pair_r.r1 : a_pair_r.r0;
  assign out_tvalid = a_valid_r;
  assign out_tdata  = {4'd0, cur.len, cur.kind};
  assign out_tlast  = a_idx_r || !a_pair_r.two;
  assign a_done     = a_valid_r && out_tready && out_tlast;
  assign a_free     = !a_valid_r || a_done;
  assign in_tready  = !b_valid_r;

  always_comb begin
    a_valid_nxt = a_valid_r;
    a_pair_nxt  = a_pair_r;
    a_idx_nxt   = a_idx_r;
    b_valid_nxt = b_valid_r;
    b_pair_nxt  = b_pair_r;
    if (a_valid_r && out_tready && !out_tlast) begin
      a_idx_nxt = 1'b1;
    end
    if (a_free) begin
      a_idx_nxt = 1'b0;
      if (b_valid_r) begin
        a_valid_nxt = 1'b1;
        a_pair_nxt  = b_pair_r;
        b_valid_nxt = in_fire && (n_res != 2'd0);
        b_pair_nxt  = new_pair;
      end else begin
        a_valid_nxt = in_fire && (n_res != 2'd0);
        a_pair_nxt  = new_pair;
      end
    end else if (in_fire && (n_res != 2'd0)) begin
      b_valid_nxt = 1'b1;
      b_pair_nxt  = new_pair;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= cltl_pkg::S_START;
      len_r     <= LW'(0);
      wm_r      <= 4'd0;
      a_valid_r <= 1'b0;
      a_idx_r   <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        st_r  <= st_nxt;
        len_r <= len_nxt;
        wm_r  <= wm_nxt;
      end
      a_valid_r <= a_valid_nxt;
      a_idx_r   <= a_idx_nxt;
      b_valid_r <= b_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_pair_r <= a_pair_nxt;
    b_pair_r <= b_pair_nxt;
  end

  // The waiting entry is never occupied while the output entry is empty.
  `CHK_ALWAYS(a_b_order, !b_valid_r || a_valid_r, "queue entry B valid while A is empty")
  // The first result of a pair is always followed by its second.
  `CHK_NEXT(pair_second, out_tvalid && out_tready && !out_tlast, out_tvalid && out_tlast,
            "second result of a pair missing")
  // An end-of-input word always leaves a result queued.
  `CHK_NEXT(end_queued, in_fire && in_tuser, a_valid_r, "end of input produced no result")
  // The token length never passes its ceiling.
  `CHK_ALWAYS(len_bound, 32'(len_r) <= 32'(cltl_pkg::MaxTokenLen),
              "token length above its ceiling")

endmodule
